>>> src/bspd_pkg.sv
// shared types and constants for the slider button position decoder
// no dependencies
`default_nettype none

package bspd_pkg;

  localparam int MAX_BUTTONS = 16;
  localparam int IDX_W       = $clog2(MAX_BUTTONS);
  localparam int CNT_W       = 5;
  localparam int DELTA_W     = 6;
  localparam int TIME_W      = 32;
  localparam int POS_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(100);

  localparam logic [CNT_W-1:0]   COUNT_RESET = CNT_W'(2);
  localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(50);

  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELTA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    STATUS_TAKEN   = 2'd0,
    STATUS_HELD    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic             found;
    logic             invalid;
    logic [POS_W-1:0] reading;
  } decode_t;

endpackage

`default_nettype wire

>>> src/bspd_decode.sv
// button pattern decode: lowest pressed button, pair detect, reading and saturation
// depends on bspd_pkg
`default_nettype none

module bspd_decode (
  input  wire logic [bspd_pkg::MAX_BUTTONS-1:0] buttons,
  input  wire logic [bspd_pkg::CNT_W-1:0]       count,
  input  wire logic [bspd_pkg::DELTA_W-1:0]     delta,
  output bspd_pkg::decode_t                     dec
);

  localparam int SLOT_W = bspd_pkg::IDX_W + 1;
  localparam int PROD_W = SLOT_W + bspd_pkg::DELTA_W;

  logic [bspd_pkg::CNT_W-1:0]       count_eff;
  logic [bspd_pkg::MAX_BUTTONS-1:0] mask;
  logic [bspd_pkg::MAX_BUTTONS-1:0] masked;
  logic [bspd_pkg::MAX_BUTTONS-1:0] low;
  logic [bspd_pkg::MAX_BUTTONS-1:0] nxt_bit;
  logic [bspd_pkg::MAX_BUTTONS-1:0] rest;
  logic [bspd_pkg::IDX_W-1:0]       idx;
  logic                             pair;
  logic [SLOT_W-1:0]                slot;
  logic [PROD_W-1:0]                prod;

  always_comb begin
    if (count > bspd_pkg::CNT_W'(bspd_pkg::MAX_BUTTONS)) begin
      count_eff = bspd_pkg::CNT_W'(bspd_pkg::MAX_BUTTONS);
    end else begin
      count_eff = count;
    end
    for (int k = 0; k < bspd_pkg::MAX_BUTTONS; k++) begin
      mask[k] = (bspd_pkg::CNT_W'(k) < count_eff);
    end
  end

  assign masked  = buttons & mask;
  assign low     = masked & (~masked + bspd_pkg::MAX_BUTTONS'(1));
  assign nxt_bit = (low << 1) & masked;
  assign rest    = masked & ~low & ~nxt_bit;
  assign pair    = |nxt_bit;

  // priority encoder, lowest pressed wins
  always_comb begin
    idx = '0;
    for (int k = bspd_pkg::MAX_BUTTONS - 1; k >= 0; k--) begin
      if (masked[k]) begin
        idx = bspd_pkg::IDX_W'(k);
      end
    end
  end

  assign slot = {idx, pair};
  assign prod = PROD_W'(slot) * PROD_W'(delta);

  always_comb begin
    dec.found   = |masked;
    dec.invalid = |rest;
    if (prod > PROD_W'(bspd_pkg::POS_MAX)) begin
      dec.reading = bspd_pkg::POS_MAX;
    end else begin
      dec.reading = prod[bspd_pkg::POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

>>> src/button_slider_position_decoder_top.sv
// slider button position decoder, top level: input register, decode, hold logic, result register
// depends on bspd_pkg and bspd_decode
// an input transfer loads the input register; its decoded result then loads the result register
// once the result register can advance
// throughput: one item per cycle unless a stalled result holds both; input and result registers advance together
// reset: synchronous active-low rst_n clears valids, stored position and hold start
// and returns the config registers to their reset values
`default_nettype none

module button_slider_position_decoder_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bspd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bspd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [bspd_pkg::MAX_BUTTONS-1:0]   in_button_states,
  input  wire logic [bspd_pkg::TIME_W-1:0]        in_now_ms,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [7:0]                       out_position,
  output logic [1:0]                              out_status
);

  logic [bspd_pkg::CNT_W-1:0]       button_count_r;
  logic [bspd_pkg::DELTA_W-1:0]     step_delta_r;
  logic [bspd_pkg::TIME_W-1:0]      hold_threshold_r;

  logic                             s1_valid_r;
  logic [bspd_pkg::MAX_BUTTONS-1:0] s1_buttons_r;
  logic [bspd_pkg::TIME_W-1:0]      s1_now_r;

  logic [bspd_pkg::POS_W-1:0]       stored_pos_r, stored_pos_nxt;
  logic [bspd_pkg::TIME_W-1:0]      hold_start_r, hold_start_nxt;

  logic                             out_valid_r;
  logic signed [7:0]                out_position_r, out_position_nxt;
  bspd_pkg::status_t                out_status_r, out_status_nxt;

  logic                             advance;
  logic [bspd_pkg::TIME_W-1:0]      elapsed;
  bspd_pkg::decode_t                dec;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;

  bspd_decode u_decode (
    .buttons (s1_buttons_r),
    .count   (button_count_r),
    .delta   (step_delta_r),
    .dec     (dec)
  );

  assign elapsed = s1_now_r - hold_start_r;

  always_comb begin
    stored_pos_nxt   = stored_pos_r;
    hold_start_nxt   = hold_start_r;
    out_position_nxt = 8'(signed'({1'b0, stored_pos_r}));
    out_status_nxt   = bspd_pkg::STATUS_HELD;
    if (dec.invalid) begin
      out_position_nxt = -8'sd1;
      out_status_nxt   = bspd_pkg::STATUS_INVALID;
    end else if (dec.found) begin
      out_status_nxt = bspd_pkg::STATUS_TAKEN;
      if (dec.reading != stored_pos_r) begin
        if (elapsed > hold_threshold_r) begin
          stored_pos_nxt   = dec.reading;
          hold_start_nxt   = s1_now_r;
          out_position_nxt = 8'(signed'({1'b0, dec.reading}));
        end
      end else begin
        hold_start_nxt = s1_now_r;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_count_r   <= bspd_pkg::COUNT_RESET;
      step_delta_r     <= bspd_pkg::DELTA_RESET;
      hold_threshold_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bspd_pkg::CFG_BUTTON_COUNT:   button_count_r   <= cfg_wdata[bspd_pkg::CNT_W-1:0];
        bspd_pkg::CFG_STEP_DELTA:     step_delta_r     <= cfg_wdata[bspd_pkg::DELTA_W-1:0];
        bspd_pkg::CFG_HOLD_THRESHOLD: hold_threshold_r <= cfg_wdata[bspd_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_buttons_r <= in_button_states;
      s1_now_r     <= in_now_ms;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_pos_r <= '0;
      hold_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        stored_pos_r <= stored_pos_nxt;
        hold_start_r <= hold_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_position_r <= out_position_nxt;
      out_status_r   <= out_status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_position = out_position_r;
  assign out_status   = out_status_r;

endmodule

`default_nettype wire

>>> src/bspd_checker.sv
// port-level checker for the slider button position decoder, bound to the top level
// depends on bspd_pkg and button_slider_position_decoder_top
`default_nettype none

module bspd_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic signed [7:0]                out_position,
  input wire logic [1:0]                       out_status
);

  // invalid status and the -1 code go together
  a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == bspd_pkg::STATUS_INVALID) == (out_position == -8'sd1)))
    else $error("invalid status and position code disagree");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bspd_pkg::STATUS_INVALID)
      |-> (out_position >= 8'sd0 && out_position <= 8'sd100))
    else $error("position out of range");

  // a new result traces back to an input transfer
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without matching input transfer");

  // input only waits when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_position) && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind button_slider_position_decoder_top bspd_checker u_bspd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_position (out_position),
  .out_status   (out_status)
);

`default_nettype wire

>>> dv/tb.sv
// testbench for the slider button position decoder: directed and random snapshots checked
// against a predictor of position, status and hold state, with random idling on both sides
// depends on bspd_pkg and button_slider_position_decoder_top
module tb;

  typedef struct packed {
    logic signed [7:0]  position;
    bspd_pkg::status_t  status;
  } slider_result_t;

  logic                                clk              = 1'b0;
  logic                                rst_n            = 1'b0;
  logic                                cfg_we           = 1'b0;
  logic [bspd_pkg::CFG_IDX_W-1:0]      cfg_index        = '0;
  logic [bspd_pkg::CFG_DATA_W-1:0]     cfg_wdata        = '0;
  logic                                in_valid         = 1'b0;
  logic                                in_stall;
  logic [bspd_pkg::MAX_BUTTONS-1:0]    in_button_states = '0;
  logic [bspd_pkg::TIME_W-1:0]         in_now_ms        = '0;
  logic                                out_valid;
  logic                                out_stall        = 1'b0;
  logic signed [7:0]                   out_position;
  logic [1:0]                          out_status;

  logic [bspd_pkg::CNT_W-1:0]   slider_count      = bspd_pkg::COUNT_RESET;
  logic [bspd_pkg::DELTA_W-1:0] slider_delta      = bspd_pkg::DELTA_RESET;
  logic [bspd_pkg::TIME_W-1:0]  hold_threshold_ms = '0;
  logic [bspd_pkg::POS_W-1:0]   stored_pos        = '0;
  logic [bspd_pkg::TIME_W-1:0]  hold_start        = '0;
  logic [bspd_pkg::TIME_W-1:0]  clock_ms          = '0;

  slider_result_t pending_positions[$];
  int unsigned    mismatches     = 0;
  int unsigned    send_gap_pct   = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_requests  = 0;

  button_slider_position_decoder_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_button_states (in_button_states),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_position     (out_position),
    .out_status       (out_status)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #200000;
    $display("tb: failure");
    $finish;
  end

  function automatic slider_result_t predict_position(
      logic [bspd_pkg::MAX_BUTTONS-1:0] buttons, logic [bspd_pkg::TIME_W-1:0] now);
    int unsigned    span;
    int unsigned    idx;
    int unsigned    reading;
    bit             found;
    bit             invalid;
    slider_result_t res;
    span    = (slider_count > bspd_pkg::MAX_BUTTONS) ? bspd_pkg::MAX_BUTTONS : slider_count;
    reading = 0;
    found   = 1'b0;
    invalid = 1'b0;
    idx     = 0;
    while (idx < span && !invalid) begin
      if (buttons[idx]) begin
        if (found) begin
          invalid = 1'b1;
        end else begin
          found   = 1'b1;
          reading = 2 * idx * slider_delta;
          if (idx + 1 < span && buttons[idx + 1]) begin
            reading += slider_delta;
            idx++;
          end
        end
      end
      idx++;
    end
    if (invalid) begin
      res.position = -8'sd1;
      res.status   = bspd_pkg::STATUS_INVALID;
    end else if (!found) begin
      res.position = 8'(stored_pos);
      res.status   = bspd_pkg::STATUS_HELD;
    end else begin
      if (reading > bspd_pkg::POS_MAX) reading = bspd_pkg::POS_MAX;
      if (reading != stored_pos) begin
        if (bspd_pkg::TIME_W'(now - hold_start) > hold_threshold_ms) begin
          stored_pos = bspd_pkg::POS_W'(reading);
          hold_start = now;
        end
      end else begin
        hold_start = now;
      end
      res.position = 8'(stored_pos);
      res.status   = bspd_pkg::STATUS_TAKEN;
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_snapshot(logic [bspd_pkg::MAX_BUTTONS-1:0] buttons,
                               logic [bspd_pkg::TIME_W-1:0] now);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_button_states <= buttons;
    in_now_ms        <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_positions.push_back(predict_position(buttons, now));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bspd_pkg::CFG_IDX_W-1:0] idx,
                           logic [bspd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bspd_pkg::CFG_BUTTON_COUNT:   slider_count      = data[bspd_pkg::CNT_W-1:0];
      bspd_pkg::CFG_STEP_DELTA:     slider_delta      = data[bspd_pkg::DELTA_W-1:0];
      bspd_pkg::CFG_HOLD_THRESHOLD: hold_threshold_ms = data[bspd_pkg::TIME_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [bspd_pkg::CNT_W-1:0] cnt, logic [bspd_pkg::DELTA_W-1:0] dlt,
                           logic [bspd_pkg::TIME_W-1:0] thr, bit noisy);
    logic [bspd_pkg::CFG_DATA_W-1:0] noise;
    drain();
    noise = noisy ? bspd_pkg::CFG_DATA_W'($urandom) : '0;
    write_reg(bspd_pkg::CFG_BUTTON_COUNT,
              {noise[bspd_pkg::CFG_DATA_W-1:bspd_pkg::CNT_W], cnt});
    write_reg(bspd_pkg::CFG_STEP_DELTA,
              {noise[bspd_pkg::CFG_DATA_W-1:bspd_pkg::DELTA_W], dlt});
    write_reg(bspd_pkg::CFG_HOLD_THRESHOLD, thr);
  endtask

  // stall side, with a long hold-off whenever one is requested
  initial begin
    int unsigned held;
    int unsigned seen;
    held = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        held = 150;
      end
      if (held != 0) begin
        out_stall <= 1'b1;
        held--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    slider_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_positions.size() == 0) begin
        report_mismatch($sformatf("result %0d/%0d with nothing pending",
                                  out_position, out_status));
      end else begin
        want = pending_positions.pop_front();
        if (out_position !== want.position)
          report_mismatch($sformatf("position %0d, predicted %0d",
                                    out_position, want.position));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
      end
    end
  end

  function automatic logic [bspd_pkg::MAX_BUTTONS-1:0] next_pattern();
    int unsigned                      span;
    int unsigned                      idx;
    int unsigned                      pick;
    logic [bspd_pkg::MAX_BUTTONS-1:0] low_mask;
    logic [bspd_pkg::MAX_BUTTONS-1:0] buttons;
    span = (slider_count == 0 || slider_count > bspd_pkg::MAX_BUTTONS) ?
           bspd_pkg::MAX_BUTTONS : slider_count;
    low_mask = (span >= bspd_pkg::MAX_BUTTONS) ? '1 :
               bspd_pkg::MAX_BUTTONS'((1 << span) - 1);
    idx  = $urandom_range(span - 1);
    pick = $urandom_range(99);
    if (pick < 45) buttons = bspd_pkg::MAX_BUTTONS'(1) << idx;
    else if (pick < 65) buttons = bspd_pkg::MAX_BUTTONS'(3) << idx;
    else if (pick < 75) buttons = '0;
    else if (pick < 85)
      buttons = (bspd_pkg::MAX_BUTTONS'(1) << idx) |
                (bspd_pkg::MAX_BUTTONS'(1) << $urandom_range(bspd_pkg::MAX_BUTTONS - 1));
    else buttons = bspd_pkg::MAX_BUTTONS'($urandom);
    // presses above the count in use
    if (pick < 65 && $urandom_range(4) == 0)
      buttons |= bspd_pkg::MAX_BUTTONS'($urandom) & ~low_mask;
    return buttons;
  endfunction

  function automatic logic [bspd_pkg::TIME_W-1:0] advance_clock();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) clock_ms += $urandom_range(25);
    else if (pick < 95) clock_ms += $urandom_range(500);
    else clock_ms += $urandom;
    return clock_ms;
  endfunction

  task automatic random_setup();
    logic [bspd_pkg::CNT_W-1:0]   cnt;
    logic [bspd_pkg::DELTA_W-1:0] dlt;
    logic [bspd_pkg::TIME_W-1:0]  thr;
    int unsigned                  pick;
    cnt = ($urandom_range(4) == 0) ? bspd_pkg::CNT_W'($urandom_range(31)) :
                                     bspd_pkg::CNT_W'($urandom_range(2, 16));
    if (cnt >= 2 && $urandom_range(4) != 0)
      dlt = bspd_pkg::DELTA_W'(bspd_pkg::POS_MAX / ((int'(cnt) - 1) * 2));
    else dlt = bspd_pkg::DELTA_W'($urandom_range(63));
    pick = $urandom_range(9);
    if (pick < 6) thr = $urandom_range(40);
    else if (pick < 8) thr = '0;
    else if (pick < 9) thr = $urandom;
    else thr = '1;
    configure(cnt, dlt, thr, 1'($urandom_range(1)));
    clock_ms = $urandom;
  endtask

  task automatic run_random_phase(int unsigned gap_pct, int unsigned stall_pct,
                                  int unsigned items);
    int unsigned                      sent;
    int unsigned                      reps;
    logic [bspd_pkg::MAX_BUTTONS-1:0] buttons;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      random_setup();
      repeat (12) begin
        buttons = next_pattern();
        reps    = $urandom_range(1, 6);
        repeat (reps) begin
          send_snapshot(buttons, advance_clock());
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_values();
    send_snapshot(16'h0000, 32'h0000_0000);
    send_snapshot(16'h0001, 32'h0000_0000);
    send_snapshot(16'h0002, 32'h0000_0001);
    send_snapshot(16'h0003, 32'h0000_0002);
    send_snapshot(16'hFFFC, 32'h0000_0003);
    send_snapshot(16'hFFFF, 32'h0000_0004);
  endtask

  task automatic test_full_row();
    configure(5'd16, 6'd3, 32'd10, 1'b1);
    send_snapshot(16'h8000, 32'hFFFF_FFF0);
    // elapsed time wraps past zero
    send_snapshot(16'hC000, 32'h0000_0003);
    send_snapshot(16'h4000, 32'h0000_0008);
    send_snapshot(16'h0005, 32'h0000_0009);
    send_snapshot(16'hFFFF, 32'h0000_000A);
    send_snapshot(16'h0001, 32'h0000_000E);
    send_snapshot(16'h0001, 32'h8000_0000);
  endtask

  task automatic test_hold_threshold();
    configure(5'd16, 6'd3, '1, 1'b0);
    send_snapshot(16'h0100, 32'h0000_0000);
    send_snapshot(16'h0100, 32'h7FFF_FFFF);
    configure(5'd16, 6'd3, '0, 1'b0);
    send_snapshot(16'h0100, 32'h8000_0000);
    send_snapshot(16'h0100, 32'h8000_0001);
  endtask

  task automatic test_count_corners();
    configure(5'd0, 6'd50, '0, 1'b1);
    send_snapshot(16'hFFFF, 32'h8000_0010);
    configure(5'd1, 6'd50, '0, 1'b0);
    send_snapshot(16'h0003, 32'h8000_0020);
    send_snapshot(16'h0002, 32'h8000_0021);
    // count above the row width, reading saturates
    configure(5'd31, 6'd63, '0, 1'b1);
    send_snapshot(16'h8000, 32'h8000_0030);
    send_snapshot(16'h0003, 32'h8000_0031);
    configure(5'd5, 6'd0, '0, 1'b0);
    send_snapshot(16'h0010, 32'h8000_0040);
  endtask

  task automatic test_backpressure();
    random_setup();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (40) send_snapshot(next_pattern(), advance_clock());
    drain();
  endtask

  task automatic test_random_traffic();
    run_random_phase(30, 70, 250);
    run_random_phase(70, 30, 250);
    run_random_phase(0, 0, 250);
  endtask

  initial begin
    send_gap_pct   = 30;
    recv_stall_pct = 70;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_full_row();
    test_hold_threshold();
    test_count_corners();
    test_backpressure();
    test_random_traffic();
    drain();
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
